// File: design/lcdn_pkg.sv
package lcdn_pkg;

  // request opcodes
  localparam logic [2:0] OP_CMD    = 3'd0;
  localparam logic [2:0] OP_DATA   = 3'd1;
  localparam logic [2:0] OP_CURSOR = 3'd2;
  localparam logic [2:0] OP_INIT   = 3'd3;
  localparam logic [2:0] OP_BUSY   = 3'd4;

  // bus action kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_POLL  = 2'd1;
  localparam logic [1:0] KIND_WAIT  = 2'd2;

  // jobs handed from front to back
  localparam logic [1:0] JOB_POLL = 2'd0;
  localparam logic [1:0] JOB_INIT = 2'd1;
  localparam logic [1:0] JOB_XFER = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_INIT_WAIT   = 2'd0;
  localparam logic [1:0] CFG_BUSY_SETTLE = 2'd1;
  localparam logic [1:0] CFG_POST_WAIT   = 2'd2;

  localparam logic [7:0] INIT_WAIT_RST   = 8'd40;
  localparam logic [7:0] BUSY_SETTLE_RST = 8'd3;
  localparam logic [7:0] POST_WAIT_RST   = 8'd20;

  localparam logic [3:0] INIT_NIB_HI   = 4'h3;
  localparam logic [3:0] INIT_NIB_LAST = 4'h2;

  localparam logic [2:0] SETUP_COUNT = 3'd6;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] value;
    logic [2:0] row;
    logic [5:0] column;
    logic       busy_flag;
  } in_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       reg_select;
    logic [3:0] nibble;
    logic [7:0] wait_us;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic [1:0] code;
    logic [7:0] byte_val;
    logic       is_data;
    logic       more;
  } job_t;

  typedef struct packed {
    logic [7:0] init_wait_us;
    logic [7:0] busy_settle_us;
    logic [7:0] post_busy_wait_us;
  } cfg_t;

  function automatic logic [7:0] setup_cmd(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0: c = 8'h28;
      3'd1: c = 8'h08;
      3'd2: c = 8'h01;
      3'd3: c = 8'h06;
      3'd4: c = 8'h0C;
      3'd5: c = 8'h02;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] row_base(input logic [2:0] row);
    logic [7:0] b;
    case (row)
      3'd1: b = 8'h80;
      3'd2: b = 8'hC0;
      3'd3: b = 8'h94;
      3'd4: b = 8'hD4;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: design/char_lcd_nibble_interface_top.sv
// channel   ports                                    direction
// input     in_push, in_full, in_data                host -> block
// result    out_empty, out_pop, out_data             block -> host
// config    cfg_valid, cfg_ready, cfg_index, cfg_data host -> block
//
// A request is classified in the cycle it is accepted; the back end then
// emits one bus word per cycle while results are taken, one to five words per
// queued job, from the single output register of the back-end sequencer.
// Requests keep being accepted while the job queue has room; a stalled
// result holds the back end but not the front. Synchronous active-low reset
// restores the register defaults and empties the queue. cfg_ready is always high.
module char_lcd_nibble_interface_top #(
  parameter int JOB_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  lcdn_pkg::in_word_t  in_data,
  output logic                out_empty,
  input  logic                out_pop,
  output lcdn_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);
  import lcdn_pkg::*;

  cfg_t  cfg_r;
  logic  accept;
  logic  job_push, job_pop, job_empty;
  job_t  push_job, head_job;
  logic  out_valid;

  assign cfg_ready = 1'b1;
  assign accept    = in_push && !in_full;
  assign out_empty = !out_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.init_wait_us      <= INIT_WAIT_RST;
      cfg_r.busy_settle_us    <= BUSY_SETTLE_RST;
      cfg_r.post_busy_wait_us <= POST_WAIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_INIT_WAIT:   cfg_r.init_wait_us      <= cfg_data;
        CFG_BUSY_SETTLE: cfg_r.busy_settle_us    <= cfg_data;
        CFG_POST_WAIT:   cfg_r.post_busy_wait_us <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  lcdn_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_word  (in_data),
    .job_push (job_push),
    .job      (push_job)
  );

  lcdn_job_fifo #(
    .DEPTH (JOB_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (push_job),
    .pop      (job_pop),
    .head_job (head_job),
    .empty    (job_empty),
    .full     (in_full)
  );

  lcdn_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job_valid (!job_empty),
    .job       (head_job),
    .job_pop   (job_pop),
    .out_valid (out_valid),
    .out_word  (out_data),
    .out_take  (out_pop)
  );

endmodule

// File: design/lcdn_front.sv
module lcdn_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  lcdn_pkg::in_word_t in_word,
  output logic              job_push,
  output lcdn_pkg::job_t    job
);
  import lcdn_pkg::*;

  logic [7:0] pending_byte_r, pending_byte_nxt;
  logic       pending_is_data_r, pending_is_data_nxt;
  logic       awaiting_busy_r, awaiting_busy_nxt;
  logic [2:0] setup_index_r, setup_index_nxt;
  logic       setup_more;
  logic [2:0] setup_inc;

  assign setup_more = (setup_index_r >= 3'd1) && (setup_index_r < SETUP_COUNT);
  assign setup_inc  = setup_index_r + 3'd1;

  always_comb begin
    pending_byte_nxt    = pending_byte_r;
    pending_is_data_nxt = pending_is_data_r;
    awaiting_busy_nxt   = awaiting_busy_r;
    setup_index_nxt     = setup_index_r;
    job_push            = 1'b0;
    job.code            = JOB_POLL;
    job.byte_val        = pending_byte_r;
    job.is_data         = pending_is_data_r;
    job.more            = 1'b0;
    if (accept) begin
      case (in_word.opcode)
        OP_CMD, OP_DATA: begin
          if (!awaiting_busy_r) begin
            pending_byte_nxt    = in_word.value;
            pending_is_data_nxt = in_word.opcode[0];
            awaiting_busy_nxt   = 1'b1;
            job_push            = 1'b1;
          end
        end
        OP_CURSOR: begin
          if (!awaiting_busy_r && in_word.row >= 3'd1 && in_word.row <= 3'd4) begin
            pending_byte_nxt    = row_base(in_word.row) + {2'b00, in_word.column} - 8'd1;
            pending_is_data_nxt = 1'b0;
            awaiting_busy_nxt   = 1'b1;
            job_push            = 1'b1;
          end
        end
        OP_INIT: begin
          if (!awaiting_busy_r) begin
            pending_byte_nxt    = setup_cmd(3'd0);
            pending_is_data_nxt = 1'b0;
            awaiting_busy_nxt   = 1'b1;
            setup_index_nxt     = 3'd1;
            job_push            = 1'b1;
            job.code            = JOB_INIT;
          end
        end
        OP_BUSY: begin
          if (awaiting_busy_r) begin
            job_push = 1'b1;
            if (!in_word.busy_flag) begin
              // send the held byte, then chain the next set-up command if one remains
              job.code          = JOB_XFER;
              job.more          = setup_more;
              awaiting_busy_nxt = 1'b0;
              if (setup_more) begin
                pending_byte_nxt    = setup_cmd(setup_index_r);
                pending_is_data_nxt = 1'b0;
                awaiting_busy_nxt   = 1'b1;
                setup_index_nxt     = (setup_inc >= SETUP_COUNT) ? 3'd0 : setup_inc;
              end else begin
                setup_index_nxt = 3'd0;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_byte_r    <= 8'h00;
      pending_is_data_r <= 1'b0;
      awaiting_busy_r   <= 1'b0;
      setup_index_r     <= 3'd0;
    end else begin
      pending_byte_r    <= pending_byte_nxt;
      pending_is_data_r <= pending_is_data_nxt;
      awaiting_busy_r   <= awaiting_busy_nxt;
      setup_index_r     <= setup_index_nxt;
    end
  end

endmodule

// File: design/lcdn_job_fifo.sv
module lcdn_job_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lcdn_pkg::job_t push_job,
  input  logic           pop,
  output lcdn_pkg::job_t head_job,
  output logic           empty,
  output logic           full
);
  import lcdn_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          slot_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign empty    = (count_r == '0);
  assign full     = (count_r == FULL_CNT);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

// File: design/lcdn_back.sv
module lcdn_back (
  input  logic               clk,
  input  logic               rst_n,
  input  lcdn_pkg::cfg_t     cfg,
  input  logic               job_valid,
  input  lcdn_pkg::job_t     job,
  output logic               job_pop,
  output logic               out_valid,
  output lcdn_pkg::out_word_t out_word,
  input  logic               out_take
);
  import lcdn_pkg::*;

  logic [2:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_word_t  out_r, out_nxt;
  out_word_t  word;
  logic       emit;

  assign out_valid = out_valid_r;
  assign out_word  = out_r;
  assign emit      = job_valid && (!out_valid_r || out_take);

  // word for the current step of the head job
  always_comb begin
    word.kind       = KIND_POLL;
    word.reg_select = 1'b0;
    word.nibble     = 4'h0;
    word.wait_us    = cfg.busy_settle_us;
    word.last       = 1'b1;
    case (job.code)
      JOB_INIT: begin
        if (step_r != 3'd4) begin
          word.kind    = KIND_WRITE;
          word.nibble  = (step_r == 3'd3) ? INIT_NIB_LAST : INIT_NIB_HI;
          word.wait_us = cfg.init_wait_us;
          word.last    = 1'b0;
        end
      end
      JOB_XFER: begin
        case (step_r)
          3'd0: begin
            word.kind    = KIND_WAIT;
            word.wait_us = cfg.post_busy_wait_us;
            word.last    = 1'b0;
          end
          3'd1: begin
            word.kind       = KIND_WRITE;
            word.reg_select = job.is_data;
            word.nibble     = job.byte_val[7:4];
            word.wait_us    = 8'd0;
            word.last       = 1'b0;
          end
          3'd2: begin
            word.kind       = KIND_WRITE;
            word.reg_select = job.is_data;
            word.nibble     = job.byte_val[3:0];
            word.wait_us    = 8'd0;
            word.last       = !job.more;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    job_pop       = 1'b0;
    if (emit) begin
      out_nxt       = word;
      out_valid_nxt = 1'b1;
      if (word.last) begin
        job_pop  = 1'b1;
        step_nxt = 3'd0;
      end else begin
        step_nxt = step_r + 3'd1;
      end
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (!rst_n) begin
      step_r      <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: dv/tb_char_lcd_nibble_interface_top.sv
module tb_char_lcd_nibble_interface_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lcdn_pkg::*;

  // opcodes the block ignores, and the register index it does not decode
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam logic [1:0] CFG_SPARE   = 2'd3;

  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 14;

  class lcd_action_tracker;
    logic [7:0] init_wait;
    logic [7:0] busy_settle;
    logic [7:0] post_wait;

    logic [7:0] pend_byte;
    logic       pend_data;
    logic       polling;
    logic [2:0] setup_pos;

    logic [7:0] setup_tab [6] = '{8'h28, 8'h08, 8'h01, 8'h06, 8'h0C, 8'h02};
    logic [7:0] base_tab  [4] = '{8'h80, 8'hC0, 8'h94, 8'hD4};

    out_word_t burst [$];
    out_word_t actions_due [$];
    int errors;
    int checked;

    function new();
      init_wait   = 8'd40;
      busy_settle = 8'd3;
      post_wait   = 8'd20;
      pend_byte   = '0;
      pend_data   = 1'b0;
      polling     = 1'b0;
      setup_pos   = '0;
      errors      = 0;
      checked     = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        CFG_INIT_WAIT:   init_wait = val;
        CFG_BUSY_SETTLE: busy_settle = val;
        CFG_POST_WAIT:   post_wait = val;
        default: ;
      endcase
    endfunction

    function void emit(logic [1:0] kind, logic rs, logic [3:0] nib, logic [7:0] w);
      out_word_t a;
      a.kind       = kind;
      a.reg_select = rs;
      a.nibble     = nib;
      a.wait_us    = w;
      a.last       = 1'b0;
      burst.push_back(a);
    endfunction

    function void begin_byte(logic [7:0] b, logic is_data);
      pend_byte = b;
      pend_data = is_data;
      polling   = 1'b1;
      emit(KIND_POLL, 1'b0, 4'h0, busy_settle);
    endfunction

    // predict the bus words caused by one accepted request; returns their count
    function int note_request(in_word_t w);
      logic [7:0] b;
      burst.delete();
      if (w.opcode <= OP_INIT && polling) return 0;
      case (w.opcode)
        OP_CMD, OP_DATA: begin
          begin_byte(w.value, w.opcode == OP_DATA);
        end
        OP_CURSOR: begin
          if (w.row >= 3'd1 && w.row <= 3'd4) begin
            b = base_tab[w.row - 3'd1] + {2'b00, w.column} - 8'd1;
            begin_byte(b, 1'b0);
          end
        end
        OP_INIT: begin
          emit(KIND_WRITE, 1'b0, INIT_NIB_HI, init_wait);
          emit(KIND_WRITE, 1'b0, INIT_NIB_HI, init_wait);
          emit(KIND_WRITE, 1'b0, INIT_NIB_HI, init_wait);
          emit(KIND_WRITE, 1'b0, INIT_NIB_LAST, init_wait);
          begin_byte(setup_tab[0], 1'b0);
          setup_pos = 3'd1;
        end
        OP_BUSY: begin
          if (polling) begin
            if (w.busy_flag) begin
              emit(KIND_POLL, 1'b0, 4'h0, busy_settle);
            end else begin
              emit(KIND_WAIT, 1'b0, 4'h0, post_wait);
              emit(KIND_WRITE, pend_data, pend_byte[7:4], 8'd0);
              emit(KIND_WRITE, pend_data, pend_byte[3:0], 8'd0);
              polling = 1'b0;
              // chain the next queued set-up command
              if (setup_pos >= 3'd1 && setup_pos < SETUP_COUNT) begin
                b = setup_tab[setup_pos];
                setup_pos = setup_pos + 3'd1;
                if (setup_pos >= SETUP_COUNT) setup_pos = '0;
                begin_byte(b, 1'b0);
              end else begin
                setup_pos = '0;
              end
            end
          end
        end
        default: ;
      endcase
      if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
      foreach (burst[i]) actions_due.push_back(burst[i]);
      return burst.size();
    endfunction

    function void check_word(out_word_t got);
      out_word_t exp;
      if (actions_due.size() == 0) begin
        $display("%0t: unexpected word: expected none", $time);
        $display("%0t:   actual kind=%0d rs=%0d nib=%h wait=%0d last=%0d",
                 $time, got.kind, got.reg_select, got.nibble, got.wait_us, got.last);
        errors++;
        return;
      end
      exp = actions_due.pop_front();
      checked++;
      if (got.kind !== exp.kind || got.reg_select !== exp.reg_select ||
          got.nibble !== exp.nibble || got.wait_us !== exp.wait_us || got.last !== exp.last) begin
        $display("%0t: mismatch: expected kind=%0d rs=%0d nib=%h wait=%0d last=%0d",
                 $time, exp.kind, exp.reg_select, exp.nibble, exp.wait_us, exp.last);
        $display("%0t:           actual   kind=%0d rs=%0d nib=%h wait=%0d last=%0d",
                 $time, got.kind, got.reg_select, got.nibble, got.wait_us, got.last);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_push = 1'b0;
  logic       in_full;
  in_word_t   in_data = '0;
  logic       out_empty;
  logic       out_pop = 1'b0;
  out_word_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  int items_in = 0;
  int useful_items = 0;
  int full_stalls = 0;

  lcd_action_tracker tracker;

  char_lcd_nibble_interface_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic in_word_t word(logic [2:0] op, logic [7:0] val, logic [2:0] row,
                                    logic [5:0] col, logic busy);
    in_word_t w;
    w.opcode    = op;
    w.value     = val;
    w.row       = row;
    w.column    = col;
    w.busy_flag = busy;
    return w;
  endfunction

  function automatic in_word_t rand_word(logic [2:0] op);
    return word(op, 8'($urandom), 3'($urandom), 6'($urandom), 1'($urandom));
  endfunction

  task automatic send_req(in_word_t w);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_full) begin
      full_stalls++;
      @(posedge clk);
    end
    items_in++;
    if (tracker.note_request(w) > 0) useful_items++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // one request, then busy responses until the byte (and any set-up chain) is out
  task automatic run_transfer();
    in_word_t w;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) w = rand_word(OP_CMD);
    else if (pick < 6) w = rand_word(OP_DATA);
    else if (pick < 9) begin
      w = rand_word(OP_CURSOR);
      w.row = 3'($urandom_range(1, 4));
    end else w = rand_word(OP_INIT);
    send_req(w);
    while (tracker.polling) begin
      if ($urandom_range(0, 7) == 0) begin
        // request while a poll is out: dropped
        send_req(rand_word(3'($urandom_range(0, 3))));
      end else begin
        w = rand_word(OP_BUSY);
        w.busy_flag = ($urandom_range(0, 3) == 0);
        send_req(w);
      end
    end
  endtask

  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (tracker.actions_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result side: pop with random gaps, plus one long hold on request
  initial begin
    int gap;
    int hold;
    gap = 0;
    hold = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) tracker.check_word(out_data);
      if (hold_req && hold == 0) begin
        hold = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        out_pop <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        out_pop <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 12) - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  initial begin
    #4ms;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [7:0] iw;
    logic [7:0] bs;
    logic [7:0] pw;
    int target;
    tracker = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset register values
    send_req(word(OP_BUSY, 8'h00, 3'd0, 6'd0, 1'b1));
    send_req(word(OP_SPARE_LO, 8'hFF, 3'd7, 6'd63, 1'b1));
    send_req(word(OP_SPARE_HI, 8'h00, 3'd0, 6'd0, 1'b0));
    send_req(word(OP_CURSOR, 8'h00, 3'd0, 6'd1, 1'b0));
    send_req(word(OP_CURSOR, 8'hFF, 3'd7, 6'd63, 1'b1));
    send_req(word(OP_CMD, 8'h00, 3'd0, 6'd0, 1'b0));
    send_req(word(OP_DATA, 8'hFF, 3'd7, 6'd63, 1'b1));
    send_req(word(OP_BUSY, 8'hFF, 3'd7, 6'd63, 1'b1));
    send_req(word(OP_BUSY, 8'h00, 3'd0, 6'd0, 1'b0));
    send_req(word(OP_DATA, 8'hFF, 3'd0, 6'd0, 1'b0));
    send_req(word(OP_BUSY, 8'h00, 3'd0, 6'd0, 1'b0));
    send_req(word(OP_CURSOR, 8'h00, 3'd1, 6'd0, 1'b0));
    send_req(word(OP_BUSY, 8'h00, 3'd0, 6'd0, 1'b0));
    send_req(word(OP_CURSOR, 8'h00, 3'd4, 6'd63, 1'b0));
    send_req(word(OP_BUSY, 8'h00, 3'd0, 6'd0, 1'b0));
    send_req(word(OP_INIT, 8'h00, 3'd0, 6'd0, 1'b0));
    send_req(word(OP_INIT, 8'h5A, 3'd2, 6'd9, 1'b0));
    repeat (6) send_req(word(OP_BUSY, 8'h00, 3'd0, 6'd0, 1'b0));
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          iw = 8'h00; bs = 8'h00; pw = 8'h00;
        end
        1: begin
          iw = 8'hFF; bs = 8'hFF; pw = 8'hFF;
        end
        default: begin
          iw = 8'($urandom); bs = 8'($urandom); pw = 8'($urandom);
        end
      endcase
      write_reg(CFG_INIT_WAIT, iw);
      write_reg(CFG_BUSY_SETTLE, bs);
      write_reg(CFG_POST_WAIT, pw);
      write_reg(CFG_SPARE, 8'($urandom));
      if (p == 2) hold_req = 1'b1;
      if (p == PHASES - 1) idle_on = 1'b0;
      target = useful_items + PHASE_ITEMS;
      while (useful_items < target) begin
        if ($urandom_range(0, 3) == 0) send_req(rand_word(3'($urandom_range(0, 7))));
        else run_transfer();
      end
      drain();
    end

    $display("Run: %0d requests accepted, %0d of them produced bus words, %0d words checked",
             items_in, useful_items, tracker.checked);
    $display("Run: %0d register settings incl. all-zero and all-ones, %0d cycles with input full",
             PHASES + 1, full_stalls);
    if (tracker.errors == 0 && tracker.actions_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: char_lcd_nibble_interface_top.f
design/lcdn_pkg.sv
design/lcdn_front.sv
design/lcdn_job_fifo.sv
design/lcdn_back.sv
design/char_lcd_nibble_interface_top.sv
dv/tb_char_lcd_nibble_interface_top.sv
